FILE: sv/cfc_pkg.sv
// Package: types, codes and sizes shared by the byte-capacity FIFO cache.
`default_nettype none

package cfc_pkg;

    localparam int KEYS      = 32;
    localparam int SLOTS     = 32;
    localparam int KEY_W     = 5;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int BYTES_W   = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CACHE_ENABLE   = 1'b0,
        CFG_CAPACITY_BYTES = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_MISS     = 3'd0,
        KIND_HIT      = 3'd1,
        KIND_INSERTED = 3'd2,
        KIND_EVICT    = 3'd3,
        KIND_NONE     = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_INSERT = 2'd2
    } t_cmd_op;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_DECIDE  = 3'd1,
        ST_RD_RING = 3'd2,
        ST_RD_SIZE = 3'd3,
        ST_EVICT   = 3'd4,
        ST_INSERT  = 3'd5
    } t_back_state;

    typedef struct packed {
        logic               req_type;
        logic               key_valid;
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] object_bytes;
    } t_req;

    typedef struct packed {
        t_kind              kind;
        logic [KEY_W-1:0]   key_out;
        logic [BYTES_W-1:0] bytes_out;
        logic [BYTES_W-1:0] occupancy;
        logic               last;
    } t_res;

    typedef struct packed {
        t_cmd_op            op;
        logic [KEY_W-1:0]   key;
        logic [BYTES_W-1:0] bytes;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/cfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/cfc_fifo.sv
// Small synchronous queue used for the command and result transactions.
`default_nettype none

module cfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output      logic             o_full,
    input  wire logic             i_pop,
    output      logic [WIDTH-1:0] o_rdata,
    output      logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cfc_front.sv
// Front end: configuration registers and request classification.
`default_nettype none

module cfc_front
    import cfc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTES_W-1:0]   i_cfg_data,
    input  wire t_req                 i_req,
    output      t_cmd                 o_cmd,
    output      logic [BYTES_W-1:0]   o_capacity
);

    localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W + 1)'(KEYS);

    logic               r_cache_enable;
    logic [BYTES_W-1:0] r_capacity_bytes;
    logic               usable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_enable   <= 1'b0;
            r_capacity_bytes <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CACHE_ENABLE: begin
                    r_cache_enable <= i_cfg_data[0];
                end
                CFG_CAPACITY_BYTES: begin
                    r_capacity_bytes <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign usable     = r_cache_enable & i_req.key_valid & ({1'b0, i_req.key} < KEY_LIMIT);
    assign o_capacity = r_capacity_bytes;

    always_comb begin
        o_cmd.key   = i_req.key;
        o_cmd.bytes = i_req.object_bytes;
        o_cmd.op    = CMD_NONE;
        if (i_req.req_type == REQ_INSERT) begin
            if (usable && (i_req.object_bytes <= r_capacity_bytes)) begin
                o_cmd.op = CMD_INSERT;
            end
        end else if (usable && (i_req.object_bytes != '0)) begin
            o_cmd.op = CMD_LOOKUP;
        end
    end

endmodule

`default_nettype wire

FILE: sv/cfc_back.sv
// Back end: sequencer that owns cache state, evicts in FIFO order and emits results.
`default_nettype none

module cfc_back
    import cfc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [BYTES_W-1:0] i_capacity,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_cmd_empty,
    output      logic               o_cmd_pop,
    output      t_res               o_res,
    output      logic               o_res_push,
    input  wire logic               i_res_full
);

    t_back_state        r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [SLOTS-1:0]   r_present, n_present;
    logic [SLOT_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BYTES_W-1:0] r_used, n_used;
    logic [KEY_W-1:0]   r_old_key, n_old_key;

    logic [KEY_W-1:0]   ring_rdata;
    logic               ring_we;
    logic [SLOT_W-1:0]  ring_waddr;
    logic [BYTES_W-1:0] size_rdata;
    logic               size_we;
    logic [SLOT_W-1:0]  size_raddr;

    logic [BYTES_W:0]   fit_sum;
    logic               must_evict;
    logic               key_present;
    logic [BYTES_W-1:0] used_after_evict;
    logic [BYTES_W-1:0] used_after_insert;

    cfc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_order_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_cmd.key),
        .i_raddr (r_head),
        .o_rdata (ring_rdata)
    );

    cfc_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (SLOTS)
    ) u_size_table (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (r_cmd.key),
        .i_wdata (r_cmd.bytes),
        .i_raddr (size_raddr),
        .o_rdata (size_rdata)
    );

    assign fit_sum           = {1'b0, r_used} + {1'b0, r_cmd.bytes};
    assign must_evict        = (r_count != '0) && (fit_sum > {1'b0, i_capacity});
    assign key_present       = r_present[r_cmd.key];
    assign used_after_evict  = (size_rdata <= r_used) ? r_used - size_rdata : '0;
    assign used_after_insert = fit_sum[BYTES_W-1:0];
    assign ring_waddr        = r_head + r_count[SLOT_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_cmd.op == CMD_INSERT && !key_present) begin
                    n_state = must_evict ? ST_RD_RING : ST_INSERT;
                end else if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_RING: begin
                n_state = ST_RD_SIZE;
            end
            ST_RD_SIZE: begin
                n_state = ST_EVICT;
            end
            ST_EVICT: begin
                if (!i_res_full) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_INSERT: begin
                if (!i_res_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop       = 1'b0;
        o_res_push      = 1'b0;
        o_res.kind      = KIND_NONE;
        o_res.key_out   = r_cmd.key;
        o_res.bytes_out = r_cmd.bytes;
        o_res.occupancy = r_used;
        o_res.last      = 1'b1;
        n_cmd           = r_cmd;
        n_present       = r_present;
        n_head          = r_head;
        n_count         = r_count;
        n_used          = r_used;
        n_old_key       = r_old_key;
        ring_we         = 1'b0;
        size_we         = 1'b0;
        size_raddr      = r_old_key;
        case (r_state)
            ST_IDLE: begin
                o_cmd_pop = ~i_cmd_empty;
                if (!i_cmd_empty) begin
                    n_cmd = i_cmd;
                end
            end
            ST_DECIDE: begin
                case (r_cmd.op)
                    CMD_LOOKUP: begin
                        o_res.kind = key_present ? KIND_HIT : KIND_MISS;
                        o_res_push = ~i_res_full;
                    end
                    CMD_INSERT: begin
                        o_res_push = key_present & ~i_res_full;
                    end
                    default: begin
                        o_res_push = ~i_res_full;
                    end
                endcase
            end
            ST_RD_SIZE: begin
                size_raddr = ring_rdata;
                n_old_key  = ring_rdata;
            end
            ST_EVICT: begin
                o_res.kind      = KIND_EVICT;
                o_res.key_out   = r_old_key;
                o_res.bytes_out = size_rdata;
                o_res.occupancy = used_after_evict;
                o_res.last      = 1'b0;
                if (!i_res_full) begin
                    o_res_push           = 1'b1;
                    n_head               = r_head + 1'b1;
                    n_count              = r_count - 1'b1;
                    n_used               = used_after_evict;
                    n_present[r_old_key] = 1'b0;
                end
            end
            ST_INSERT: begin
                o_res.kind      = KIND_INSERTED;
                o_res.occupancy = used_after_insert;
                if (!i_res_full) begin
                    o_res_push           = 1'b1;
                    size_we              = 1'b1;
                    n_used               = used_after_insert;
                    n_present[r_cmd.key] = 1'b1;
                    if (r_count < CNT_W'(SLOTS)) begin
                        ring_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_present <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_used    <= '0;
        end else begin
            r_state   <= n_state;
            r_present <= n_present;
            r_head    <= n_head;
            r_count   <= n_count;
            r_used    <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_old_key <= n_old_key;
    end

endmodule

`default_nettype wire

FILE: sv/fifo_byte_capacity_cache_unit.sv
// Top level of the byte-capacity FIFO cache: front end, command queue, back end, result queue.
// Requests enter through push/full into a short command queue; results leave through
// empty/pop from a result queue, so both sides stall independently. The back-end sequencer
// answers a lookup or a request without action from its decide state, and an insert from
// its insert state; each eviction first passes through the chained registered reads of the
// order ring and then the size table, then the evict state, and returns to the decide state.
`default_nettype none

module fifo_byte_capacity_cache_unit
    import cfc_pkg::*;
#(
    parameter int CMD_Q_DEPTH = CMD_DEPTH,
    parameter int RES_Q_DEPTH = RES_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    input  wire t_req                 i_req,
    output      logic                 full,
    input  wire logic                 pop,
    output      t_res                 o_res,
    output      logic                 empty,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTES_W-1:0]   i_cfg_data
);

    t_cmd               front_cmd;
    t_cmd               back_cmd;
    logic [BYTES_W-1:0] capacity;
    logic               cmd_empty;
    logic               cmd_pop;
    t_res               back_res;
    logic               res_push;
    logic               res_full;

    cfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_cmd      (front_cmd),
        .o_capacity (capacity)
    );

    cfc_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_rdata (back_cmd),
        .o_empty (cmd_empty)
    );

    cfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (capacity),
        .i_cmd       (back_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    cfc_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (o_res),
        .o_empty (empty)
    );

endmodule

`default_nettype wire
